// ----- sv/cpurf_pkg.sv -----
package cpurf_pkg;

  typedef logic [7:0][7:0] regs_t;

  typedef enum logic [4:0] {
    ACT_RD       = 5'd0,
    ACT_WR       = 5'd1,
    ACT_RDPAIR   = 5'd2,
    ACT_WRPAIR   = 5'd3,
    ACT_ADD      = 5'd4,
    ACT_ADC      = 5'd5,
    ACT_SUB      = 5'd6,
    ACT_SBC      = 5'd7,
    ACT_AND      = 5'd8,
    ACT_XOR      = 5'd9,
    ACT_OR       = 5'd10,
    ACT_CP       = 5'd11,
    ACT_ADDHL    = 5'd12,
    ACT_INC      = 5'd13,
    ACT_INCPAIR  = 5'd14,
    ACT_DEC      = 5'd15,
    ACT_DECPAIR  = 5'd16,
    ACT_RRA      = 5'd17,
    ACT_RLA      = 5'd18,
    ACT_RLCA     = 5'd19,
    ACT_RRCA     = 5'd20,
    ACT_RR       = 5'd21,
    ACT_RL       = 5'd22,
    ACT_RRC      = 5'd23,
    ACT_RLC      = 5'd24,
    ACT_SLA      = 5'd25,
    ACT_SRA      = 5'd26,
    ACT_SRL      = 5'd27,
    ACT_SWAP     = 5'd28,
    ACT_FLAGSET  = 5'd29,
    ACT_FLAGCLR  = 5'd30,
    ACT_FLAGGET  = 5'd31
  } act_e;

  typedef enum logic [2:0] {
    SH_RR, SH_RL, SH_RRC, SH_RLC, SH_SLA, SH_SRA, SH_SRL, SH_SWAP
  } shift_e;

  localparam logic [2:0] IDX_H = 3'd4;
  localparam logic [2:0] IDX_L = 3'd5;
  localparam logic [2:0] IDX_A = 3'd6;
  localparam logic [2:0] IDX_F = 3'd7;

  localparam int BIT_Z = 7;
  localparam int BIT_N = 6;
  localparam int BIT_H = 5;
  localparam int BIT_C = 4;

  // B C D E H L A F from byte 0 up
  localparam regs_t REG_RESET = 64'hB0_01_4D_01_D8_00_13_00;

  typedef struct packed {
    act_e        action;
    logic [2:0]  reg_index;
    logic [2:0]  pair_high_index;
    logic [2:0]  pair_low_index;
    logic [15:0] operand;
    logic [2:0]  flag_bit;
  } item_t;

  typedef struct packed {
    logic [15:0] read_value;
    logic [3:0]  flags_now;
    logic        flag_read;
  } result_t;

endpackage

// ----- sv/cpurf_exec.sv -----
module cpurf_exec (
  input  cpurf_pkg::regs_t   regs,
  input  cpurf_pkg::item_t   item,
  output cpurf_pkg::regs_t   regs_next,
  output cpurf_pkg::result_t res
);
  import cpurf_pkg::*;

  regs_t       rf;
  logic [7:0]  a;
  logic [7:0]  b;
  logic        cin;
  logic [8:0]  r9;
  logic [4:0]  r5;
  logic [15:0] v16;
  logic [16:0] r17;
  logic [12:0] r13;
  logic [7:0]  v8;
  logic [7:0]  r8;
  logic        nc;
  logic        acc;
  logic [2:0]  tg;
  shift_e      kind;
  logic [15:0] rv;
  logic        fr;

  always_comb begin
    rf   = regs;
    a    = regs[IDX_A];
    b    = item.operand[7:0];
    cin  = regs[IDX_F][BIT_C];
    r9   = '0;
    r5   = '0;
    v16  = '0;
    r17  = '0;
    r13  = '0;
    v8   = '0;
    r8   = '0;
    nc   = 1'b0;
    acc  = 1'b0;
    tg   = item.reg_index;
    kind = SH_RR;
    rv   = '0;
    fr   = 1'b0;

    unique case (item.action)
      ACT_RD: begin
        rv = {8'h00, rf[item.reg_index]};
      end
      ACT_WR: begin
        rf[item.reg_index] = b;
        rv = {8'h00, b};
      end
      ACT_RDPAIR: begin
        rv = {rf[item.pair_high_index], rf[item.pair_low_index]};
      end
      ACT_WRPAIR: begin
        rf[item.pair_high_index] = item.operand[15:8];
        rf[item.pair_low_index]  = item.operand[7:0];
        rv = item.operand;
      end
      ACT_ADD, ACT_ADC: begin
        if (item.action == ACT_ADD) cin = 1'b0;
        r9 = {1'b0, a} + {1'b0, b} + {8'h00, cin};
        r5 = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'h0, cin};
        rf[IDX_A] = r9[7:0];
        rf[IDX_F][BIT_Z] = (r9[7:0] == 8'h00);
        rf[IDX_F][BIT_N] = 1'b0;
        rf[IDX_F][BIT_H] = r5[4];
        rf[IDX_F][BIT_C] = r9[8];
        rv = {8'h00, r9[7:0]};
      end
      ACT_SUB, ACT_SBC, ACT_CP: begin
        if (item.action != ACT_SBC) cin = 1'b0;
        r9 = {1'b0, a} - {1'b0, b} - {8'h00, cin};
        r5 = {1'b0, a[3:0]} - {1'b0, b[3:0]} - {4'h0, cin};
        if (item.action != ACT_CP) rf[IDX_A] = r9[7:0];
        rf[IDX_F][BIT_Z] = (r9[7:0] == 8'h00);
        rf[IDX_F][BIT_N] = 1'b1;
        rf[IDX_F][BIT_H] = r5[4];
        rf[IDX_F][BIT_C] = r9[8];
        rv = {8'h00, r9[7:0]};
      end
      ACT_AND, ACT_XOR, ACT_OR: begin
        if (item.action == ACT_AND)      r8 = a & b;
        else if (item.action == ACT_XOR) r8 = a ^ b;
        else                             r8 = a | b;
        rf[IDX_A] = r8;
        rf[IDX_F][BIT_Z] = (r8 == 8'h00);
        rf[IDX_F][BIT_N] = 1'b0;
        rf[IDX_F][BIT_H] = (item.action == ACT_AND);
        rf[IDX_F][BIT_C] = 1'b0;
        rv = {8'h00, r8};
      end
      ACT_ADDHL: begin
        v16 = {rf[IDX_H], rf[IDX_L]};
        r17 = {1'b0, v16} + {1'b0, item.operand};
        r13 = {1'b0, v16[11:0]} + {1'b0, item.operand[11:0]};
        rf[IDX_H] = r17[15:8];
        rf[IDX_L] = r17[7:0];
        rf[IDX_F][BIT_N] = 1'b0;
        rf[IDX_F][BIT_H] = r13[12];
        rf[IDX_F][BIT_C] = r17[16];
        rv = r17[15:0];
      end
      ACT_INC, ACT_DEC: begin
        v8 = rf[item.reg_index];
        r8 = (item.action == ACT_INC) ? v8 + 8'd1 : v8 - 8'd1;
        rf[item.reg_index] = r8;
        rf[IDX_F][BIT_Z] = (r8 == 8'h00);
        rf[IDX_F][BIT_N] = (item.action == ACT_DEC);
        rf[IDX_F][BIT_H] = (item.action == ACT_INC) ? (v8[3:0] == 4'hF)
                                                    : (v8[3:0] == 4'h0);
        rv = {8'h00, rf[item.reg_index]};
      end
      ACT_INCPAIR, ACT_DECPAIR: begin
        v16 = {rf[item.pair_high_index], rf[item.pair_low_index]};
        v16 = (item.action == ACT_INCPAIR) ? v16 + 16'd1 : v16 - 16'd1;
        rf[item.pair_high_index] = v16[15:8];
        rf[item.pair_low_index]  = v16[7:0];
        rv = {rf[item.pair_high_index], rf[item.pair_low_index]};
      end
      ACT_FLAGSET: begin
        rf[IDX_F][item.flag_bit] = 1'b1;
        rv = {8'h00, rf[IDX_F]};
      end
      ACT_FLAGCLR: begin
        rf[IDX_F][item.flag_bit] = 1'b0;
        rv = {8'h00, rf[IDX_F]};
      end
      ACT_FLAGGET: begin
        rv = {8'h00, rf[IDX_F]};
        fr = rf[IDX_F][item.flag_bit];
      end
      ACT_RRA, ACT_RLA, ACT_RLCA, ACT_RRCA, ACT_RR, ACT_RL, ACT_RRC,
      ACT_RLC, ACT_SLA, ACT_SRA, ACT_SRL, ACT_SWAP: begin
        acc = (item.action <= ACT_RRCA);
        tg  = acc ? IDX_A : item.reg_index;
        case (item.action)
          ACT_RRA, ACT_RR:   kind = SH_RR;
          ACT_RLA, ACT_RL:   kind = SH_RL;
          ACT_RRCA, ACT_RRC: kind = SH_RRC;
          ACT_RLCA, ACT_RLC: kind = SH_RLC;
          ACT_SLA:           kind = SH_SLA;
          ACT_SRA:           kind = SH_SRA;
          ACT_SRL:           kind = SH_SRL;
          default:           kind = SH_SWAP;
        endcase
        v8 = rf[tg];
        unique case (kind)
          SH_RR:   begin nc = v8[0]; r8 = {cin, v8[7:1]};     end
          SH_RL:   begin nc = v8[7]; r8 = {v8[6:0], cin};     end
          SH_RRC:  begin nc = v8[0]; r8 = {v8[0], v8[7:1]};   end
          SH_RLC:  begin nc = v8[7]; r8 = {v8[6:0], v8[7]};   end
          SH_SLA:  begin nc = v8[7]; r8 = {v8[6:0], 1'b0};    end
          SH_SRA:  begin nc = v8[0]; r8 = {v8[7], v8[7:1]};   end
          SH_SRL:  begin nc = v8[0]; r8 = {1'b0, v8[7:1]};    end
          SH_SWAP: begin nc = 1'b0;  r8 = {v8[3:0], v8[7:4]}; end
        endcase
        rf[tg] = r8;
        rf[IDX_F][BIT_Z] = acc ? 1'b0 : (r8 == 8'h00);
        rf[IDX_F][BIT_N] = 1'b0;
        rf[IDX_F][BIT_H] = 1'b0;
        rf[IDX_F][BIT_C] = nc;
        rv = {8'h00, rf[tg]};
      end
    endcase

    regs_next     = rf;
    res.read_value = rv;
    res.flags_now  = rf[IDX_F][7:4];
    res.flag_read  = fr;
  end

endmodule

// ----- sv/cpu_register_file_and_alu_core.sv -----
// An accepted word is registered into item, executed combinationally, and its result is registered and strobed by done.
// Throughput: one word per cycle; busy stays low, the execute step is one short pass.
// Register file updates in order, so each word sees the effect of the one before.
// Reset (rst, synchronous): registers take their boot values, nothing in flight.
// The receiver cannot stall: each result is marked by done for exactly one cycle and held until the next result.
module cpu_register_file_and_alu_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [4:0]  action,
  input  logic [2:0]  reg_index,
  input  logic [2:0]  pair_high_index,
  input  logic [2:0]  pair_low_index,
  input  logic [15:0] operand,
  input  logic [2:0]  flag_bit,
  output logic        done,
  output logic [15:0] read_value,
  output logic [3:0]  flags_now,
  output logic        flag_read
);
  import cpurf_pkg::*;

  regs_t   regs;
  regs_t   regs_next;
  item_t   item;
  logic    item_valid;
  result_t res;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else begin
      item_valid <= start && !busy;
    end
    if (start && !busy) begin
      item.action          <= act_e'(action);
      item.reg_index       <= reg_index;
      item.pair_high_index <= pair_high_index;
      item.pair_low_index  <= pair_low_index;
      item.operand         <= operand;
      item.flag_bit        <= flag_bit;
    end
  end

  cpurf_exec u_exec (
    .regs      (regs),
    .item      (item),
    .regs_next (regs_next),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      regs <= REG_RESET;
      done <= 1'b0;
    end else begin
      done <= item_valid;
      if (item_valid) begin
        regs <= regs_next;
      end
    end
    if (item_valid) begin
      read_value <= res.read_value;
      flags_now  <= res.flags_now;
      flag_read  <= res.flag_read;
    end
  end

`ifndef SYNTHESIS
  a_two_cycle_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##2 done)
    else $error("accepted word did not produce a result two cycles later");

  a_regs_hold_when_idle: assert property (@(posedge clk) disable iff (rst)
    !item_valid |=> $stable(regs))
    else $error("register file changed with no word executing");

  a_flags_track_f: assert property (@(posedge clk) disable iff (rst)
    done |-> (flags_now == regs[IDX_F][7:4]))
    else $error("reported flags differ from F");
`endif

endmodule
